// File: design/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants for the I2C master bit engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

	// command codes
	localparam logic [2:0] CMD_IDLE  = 3'd0;
	localparam logic [2:0] CMD_START = 3'd1;
	localparam logic [2:0] CMD_STOP  = 3'd2;
	localparam logic [2:0] CMD_WRITE = 3'd3;
	localparam logic [2:0] CMD_ACK   = 3'd4;
	localparam logic [2:0] CMD_READ  = 3'd5;

	// configuration register indexes
	localparam logic CFG_TICKS_PER_US = 1'b0;
	localparam logic CFG_ACK_TIMEOUT  = 1'b1;

	localparam int CFG_W = 8;
	localparam logic [CFG_W-1:0] TICKS_PER_US_RST = 8'd16;
	localparam logic [CFG_W-1:0] ACK_TIMEOUT_RST  = 8'd250;

	// result word
	typedef struct packed {
		logic       scl_drive;
		logic       sda_drive;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_data;
		logic       ack_failed;
	} res_t;

endpackage

// File: design/i2cm_core.sv
// ----------------------------------------------------------------------------
// i2cm_core
// Bus phase sequencer: per-tick command decode, phase timing and pin state.
// ----------------------------------------------------------------------------
module i2cm_core
	import i2cm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             step_en,
	input  logic [2:0]       op,
	input  logic [7:0]       write_data,
	input  logic             send_ack,
	input  logic             sda_level,
	output res_t             res
);

	localparam logic [2:0] STEP_0 = 3'd0;
	localparam logic [2:0] STEP_1 = 3'd1;
	localparam logic [2:0] STEP_2 = 3'd2;
	localparam logic [2:0] STEP_3 = 3'd3;
	localparam logic [2:0] STEP_4 = 3'd4;

	logic [CFG_W-1:0] ticks_q, tmo_cfg_q;
	logic [2:0]  cmd_q, n_cmd;
	logic [2:0]  step_q, n_step;
	logic [3:0]  bit_q, n_bit, bit_inc;
	logic [7:0]  shift_q, n_shift;
	logic [9:0]  delay_q, n_delay;
	logic [7:0]  tmo_q, n_tmo, tmo_inc;
	logic        scl_q, n_scl, sda_q, n_sda, err_q, n_err, ackc_q, n_ackc;
	logic [7:0]  last_q, n_last;
	logic        done, run;
	logic [7:0]  t_eff, lim;
	logic [9:0]  w1, w2, w4;

	// zero in either register acts as one
	assign t_eff = (ticks_q == '0) ? 8'd1 : ticks_q;
	assign lim   = (tmo_cfg_q == '0) ? 8'd1 : tmo_cfg_q;
	assign w1    = {2'b00, t_eff} - 10'd1;
	assign w2    = {1'b0, t_eff, 1'b0} - 10'd1;
	assign w4    = {t_eff, 2'b00} - 10'd1;

	always_comb begin
		n_cmd   = cmd_q;
		n_step  = step_q;
		n_bit   = bit_q;
		n_shift = shift_q;
		n_delay = delay_q;
		n_tmo   = tmo_q;
		n_scl   = scl_q;
		n_sda   = sda_q;
		n_err   = err_q;
		n_ackc  = ackc_q;
		n_last  = last_q;
		done    = 1'b0;
		run     = 1'b0;
		bit_inc = bit_q + 4'd1;
		tmo_inc = tmo_q + 8'd1;
		if (step_en) begin
			if (cmd_q == CMD_IDLE) begin
				if (op >= CMD_START && op <= CMD_READ) begin
					n_cmd   = op;
					n_step  = STEP_0;
					n_bit   = '0;
					n_delay = '0;
					if (op == CMD_WRITE) n_shift = write_data;
					if (op == CMD_READ) begin
						n_shift = '0;
						n_ackc  = send_ack;
					end
					run = 1'b1;
				end
			end else if (delay_q != '0) begin
				n_delay = delay_q - 10'd1;
			end else begin
				run = 1'b1;
			end
		end
		bit_inc = n_bit + 4'd1;
		tmo_inc = n_tmo + 8'd1;
		if (run) begin
			unique case (n_cmd)
				CMD_START: begin
					if (n_step == STEP_0) begin
						n_sda = 1'b1; n_scl = 1'b1; n_delay = w4; n_step = STEP_1;
					end else if (n_step == STEP_1) begin
						n_sda = 1'b0; n_delay = w4; n_step = STEP_2;
					end else begin
						n_scl = 1'b0; n_cmd = CMD_IDLE; n_step = STEP_0; done = 1'b1;
					end
				end
				CMD_STOP: begin
					if (n_step == STEP_0) begin
						n_scl = 1'b0; n_sda = 1'b0; n_delay = w4; n_step = STEP_1;
					end else if (n_step == STEP_1) begin
						n_scl = 1'b1; n_delay = w4; n_step = STEP_2;
					end else if (n_step == STEP_2) begin
						n_sda = 1'b1; n_delay = w4; n_step = STEP_3;
					end else begin
						n_cmd = CMD_IDLE; n_step = STEP_0; done = 1'b1;
					end
				end
				CMD_ACK: begin
					if (n_step == STEP_0) begin
						n_sda = 1'b1; n_tmo = '0; n_err = 1'b0;
						n_delay = w1; n_step = STEP_1;
					end else if (n_step == STEP_1) begin
						n_scl = 1'b1; n_delay = w1; n_step = STEP_2;
					end else if (!sda_level) begin
						n_scl = 1'b0; n_err = 1'b0;
						n_cmd = CMD_IDLE; n_step = STEP_0; done = 1'b1;
					end else begin
						n_tmo = tmo_inc;
						// give up: flag and fall into the stop sequence
						if (tmo_inc >= lim) begin
							n_err = 1'b1;
							n_cmd = CMD_STOP;
							n_scl = 1'b0; n_sda = 1'b0; n_delay = w4; n_step = STEP_1;
						end
					end
				end
				CMD_WRITE: begin
					if (n_step == STEP_0) begin
						n_scl   = 1'b0;
						n_sda   = n_shift[7];
						n_shift = {n_shift[6:0], 1'b0};
						n_delay = w2; n_step = STEP_1;
					end else if (n_step == STEP_1) begin
						n_scl = 1'b1; n_delay = w2; n_step = STEP_2;
					end else if (n_step == STEP_2) begin
						n_scl = 1'b0; n_delay = w2; n_bit = bit_inc;
						n_step = (bit_inc >= 4'd8) ? STEP_3 : STEP_0;
					end else begin
						n_cmd = CMD_IDLE; n_step = STEP_0; done = 1'b1;
					end
				end
				CMD_READ: begin
					if (n_step == STEP_0) begin
						n_scl = 1'b0; n_sda = 1'b1; n_delay = w2; n_step = STEP_1;
					end else if (n_step == STEP_1) begin
						// sample on the rising scl phase
						n_scl   = 1'b1;
						n_shift = {n_shift[6:0], sda_level};
						n_delay = w1; n_bit = bit_inc;
						n_step  = (bit_inc >= 4'd8) ? STEP_2 : STEP_0;
					end else if (n_step == STEP_2) begin
						n_scl = 1'b0; n_sda = ~n_ackc; n_delay = w2; n_step = STEP_3;
					end else if (n_step == STEP_3) begin
						n_scl = 1'b1; n_delay = w2; n_step = STEP_4;
					end else begin
						n_scl = 1'b0; n_last = n_shift;
						n_cmd = CMD_IDLE; n_step = STEP_0; done = 1'b1;
					end
				end
				default: begin
					n_cmd  = CMD_IDLE;
					n_step = STEP_0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q   <= TICKS_PER_US_RST;
			tmo_cfg_q <= ACK_TIMEOUT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TICKS_PER_US: ticks_q   <= cfg_data;
				CFG_ACK_TIMEOUT:  tmo_cfg_q <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q   <= CMD_IDLE;
			step_q  <= STEP_0;
			bit_q   <= '0;
			shift_q <= '0;
			delay_q <= '0;
			tmo_q   <= '0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			err_q   <= 1'b0;
			ackc_q  <= 1'b0;
			last_q  <= '0;
		end else if (step_en) begin
			cmd_q   <= n_cmd;
			step_q  <= n_step;
			bit_q   <= n_bit;
			shift_q <= n_shift;
			delay_q <= n_delay;
			tmo_q   <= n_tmo;
			scl_q   <= n_scl;
			sda_q   <= n_sda;
			err_q   <= n_err;
			ackc_q  <= n_ackc;
			last_q  <= n_last;
		end
	end

	assign res.scl_drive  = n_scl;
	assign res.sda_drive  = n_sda;
	assign res.busy_res   = (n_cmd != CMD_IDLE);
	assign res.done_res   = done;
	assign res.read_data  = n_last;
	assign res.ack_failed = n_err;

endmodule

// File: design/i2cm_obuf.sv
// ----------------------------------------------------------------------------
// i2cm_obuf
// Result register with a skid stage, so the input stall is registered.
// ----------------------------------------------------------------------------
module i2cm_obuf
	import i2cm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  res_t din,
	output logic full,
	output logic out_valid,
	input  logic out_stall,
	output res_t dout
);

	logic main_valid_q, skid_valid_q, take;
	res_t main_q, skid_q;

	assign take      = main_valid_q & ~out_stall;
	assign full      = skid_valid_q;
	assign out_valid = main_valid_q;
	assign dout      = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) skid_valid_q <= 1'b0;
		end else if (wr_en) begin
			// main busy and held: park the word in the skid stage
			if (main_valid_q && !take) skid_valid_q <= 1'b1;
			else main_valid_q <= 1'b1;
		end else if (take) begin
			main_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) main_q <= skid_q;
		end else if (wr_en) begin
			if (main_valid_q && !take) skid_q <= din;
			else main_q <= din;
		end
	end

endmodule

// File: design/i2c_master_bit_engine.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_engine
// Pin-level I2C master: start, stop, write byte, wait ack, read byte.
// ----------------------------------------------------------------------------
// Every accepted word is one bus tick and yields exactly one result word; a new
// word can be taken on every cycle unless in_stall holds it off. The result word
// is built combinationally from the sequencer's next state and registered in the
// result register, or in the skid stage while it is held; this two-word output
// buffer keeps in_stall registered: input is held off only while both are full.
// Phase waits last 1, 2 or 4 times ticks_per_us ticks.
module i2c_master_bit_engine
	import i2cm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [2:0]       op,
	input  logic [7:0]       write_data,
	input  logic             send_ack,
	input  logic             sda_level,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             scl_drive,
	output logic             sda_drive,
	output logic             busy_res,
	output logic             done_res,
	output logic [7:0]       read_data,
	output logic             ack_failed
);

	logic accept;
	res_t core_res, buf_res;

	assign accept = in_valid & ~in_stall;

	i2cm_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.step_en    (accept),
		.op         (op),
		.write_data (write_data),
		.send_ack   (send_ack),
		.sda_level  (sda_level),
		.res        (core_res)
	);

	i2cm_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (accept),
		.din       (core_res),
		.full      (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.dout      (buf_res)
	);

	assign scl_drive  = buf_res.scl_drive;
	assign sda_drive  = buf_res.sda_drive;
	assign busy_res   = buf_res.busy_res;
	assign done_res   = buf_res.done_res;
	assign read_data  = buf_res.read_data;
	assign ack_failed = buf_res.ack_failed;

endmodule

// File: design/i2cm_chk.sv
// ----------------------------------------------------------------------------
// i2cm_chk
// Port-level checks for the I2C master bit engine, bound to the top level.
// ----------------------------------------------------------------------------
module i2cm_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic       scl_drive,
	input logic       sda_drive,
	input logic       busy_res,
	input logic       done_res,
	input logic [7:0] read_data,
	input logic       ack_failed
);

	// a held result word keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(scl_drive) && $stable(sda_drive)
			&& $stable(busy_res) && $stable(done_res) && $stable(read_data)
			&& $stable(ack_failed))
		else $error("result word changed while stalled");

	// input only held off while a result is waiting
	a_stall_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with empty output");

	// completion ends the command
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !busy_res)
		else $error("done while still busy");

	// an accepted word with room downstream always yields a result
	a_accept_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> out_valid)
		else $error("accepted word produced no result");

endmodule

bind i2c_master_bit_engine i2cm_chk u_i2cm_chk (.*);

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the I2C master bit engine. A cycle-level model of
// the sequencer predicts the pin word that each bus tick produces. Traffic is
// directed corner cases first, then random start/byte/ack/stop transfers with
// noise, under several timing settings and random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
	import i2cm_pkg::*;

	// op codes with no command behind them
	localparam logic [2:0] OP_SPARE_LO = 3'd6;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;
	localparam int WATCHDOG_LIMIT = 2000;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic             cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic             in_valid;
	logic             in_stall;
	logic [2:0]       op;
	logic [7:0]       write_data;
	logic             send_ack;
	logic             sda_level;
	logic             out_valid;
	logic             out_stall;
	logic             scl_drive;
	logic             sda_drive;
	logic             busy_res;
	logic             done_res;
	logic [7:0]       read_data;
	logic             ack_failed;

	i2c_master_bit_engine u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.write_data (write_data),
		.send_ack   (send_ack),
		.sda_level  (sda_level),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.scl_drive  (scl_drive),
		.sda_drive  (sda_drive),
		.busy_res   (busy_res),
		.done_res   (done_res),
		.read_data  (read_data),
		.ack_failed (ack_failed)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// engine model state
	logic [7:0] tpu_reg;
	logic [7:0] ato_reg;
	logic [2:0] eng_cmd;
	logic [3:0] eng_step;
	logic [3:0] eng_bits;
	logic [7:0] eng_shift;
	logic [9:0] eng_delay;
	logic [7:0] eng_polls;
	logic       eng_scl;
	logic       eng_sda;
	logic       eng_fail;
	logic [7:0] eng_rd;
	logic       eng_ack_sel;
	logic       eng_done;

	res_t pin_words_due[$];
	int   n_ticks;
	int   n_checked;
	int   n_bad;
	int   n_timeouts;
	int   n_settings;
	int   idle_cycles;
	int   cmd_count [8];
	bit   tx_steady;
	bit   rx_steady;

	task automatic engine_reset();
		tpu_reg = TICKS_PER_US_RST;
		ato_reg = ACK_TIMEOUT_RST;
		eng_cmd = CMD_IDLE;
		eng_step = 4'd0;
		eng_bits = 4'd0;
		eng_shift = 8'd0;
		eng_delay = 10'd0;
		eng_polls = 8'd0;
		eng_scl = 1'b1;
		eng_sda = 1'b1;
		eng_fail = 1'b0;
		eng_rd = 8'd0;
		eng_ack_sel = 1'b0;
		eng_done = 1'b0;
	endtask

	// phase wait counts from the tick that sets the pins up
	task automatic load_wait(input int units);
		int t;
		t = (tpu_reg == 8'd0) ? 1 : int'(tpu_reg);
		eng_delay = 10'(units * t - 1);
	endtask

	task automatic enter_stop();
		eng_cmd = CMD_STOP;
		eng_scl = 1'b0;
		eng_sda = 1'b0;
		load_wait(4);
		eng_step = 4'd1;
	endtask

	task automatic end_cmd();
		eng_cmd = CMD_IDLE;
		eng_step = 4'd0;
		eng_done = 1'b1;
	endtask

	task automatic run_step(input logic sda_in);
		int lim;
		lim = (ato_reg == 8'd0) ? 1 : int'(ato_reg);
		case (eng_cmd)
			CMD_START: begin
				if (eng_step == 4'd0) begin
					eng_sda = 1'b1;
					eng_scl = 1'b1;
					load_wait(4);
					eng_step = 4'd1;
				end else if (eng_step == 4'd1) begin
					eng_sda = 1'b0;
					load_wait(4);
					eng_step = 4'd2;
				end else begin
					eng_scl = 1'b0;
					end_cmd();
				end
			end
			CMD_STOP: begin
				if (eng_step == 4'd0) begin
					enter_stop();
				end else if (eng_step == 4'd1) begin
					eng_scl = 1'b1;
					load_wait(4);
					eng_step = 4'd2;
				end else if (eng_step == 4'd2) begin
					eng_sda = 1'b1;
					load_wait(4);
					eng_step = 4'd3;
				end else begin
					end_cmd();
				end
			end
			CMD_ACK: begin
				if (eng_step == 4'd0) begin
					eng_sda = 1'b1;
					eng_polls = 8'd0;
					eng_fail = 1'b0;
					load_wait(1);
					eng_step = 4'd1;
				end else if (eng_step == 4'd1) begin
					eng_scl = 1'b1;
					load_wait(1);
					eng_step = 4'd2;
				end else if (!sda_in) begin
					eng_scl = 1'b0;
					eng_fail = 1'b0;
					end_cmd();
				end else begin
					eng_polls = eng_polls + 8'd1;
					// give up and release the bus with a stop
					if (int'(eng_polls) >= lim) begin
						eng_fail = 1'b1;
						n_timeouts++;
						enter_stop();
					end
				end
			end
			CMD_WRITE: begin
				if (eng_step == 4'd0) begin
					eng_scl = 1'b0;
					eng_sda = eng_shift[7];
					eng_shift = {eng_shift[6:0], 1'b0};
					load_wait(2);
					eng_step = 4'd1;
				end else if (eng_step == 4'd1) begin
					eng_scl = 1'b1;
					load_wait(2);
					eng_step = 4'd2;
				end else if (eng_step == 4'd2) begin
					eng_scl = 1'b0;
					load_wait(2);
					eng_bits = eng_bits + 4'd1;
					eng_step = (eng_bits >= 4'd8) ? 4'd3 : 4'd0;
				end else begin
					end_cmd();
				end
			end
			CMD_READ: begin
				if (eng_step == 4'd0) begin
					eng_scl = 1'b0;
					eng_sda = 1'b1;
					load_wait(2);
					eng_step = 4'd1;
				end else if (eng_step == 4'd1) begin
					// data is taken as scl is released
					eng_scl = 1'b1;
					eng_shift = {eng_shift[6:0], sda_in};
					load_wait(1);
					eng_bits = eng_bits + 4'd1;
					eng_step = (eng_bits >= 4'd8) ? 4'd2 : 4'd0;
				end else if (eng_step == 4'd2) begin
					eng_scl = 1'b0;
					eng_sda = eng_ack_sel ? 1'b0 : 1'b1;
					load_wait(2);
					eng_step = 4'd3;
				end else if (eng_step == 4'd3) begin
					eng_scl = 1'b1;
					load_wait(2);
					eng_step = 4'd4;
				end else begin
					eng_scl = 1'b0;
					eng_rd = eng_shift;
					end_cmd();
				end
			end
			default: begin
				eng_cmd = CMD_IDLE;
				eng_step = 4'd0;
			end
		endcase
	endtask

	task automatic engine_tick(input logic [2:0] op_in, input logic [7:0] byte_in,
			input logic ack_in, input logic sda_in, output res_t word);
		eng_done = 1'b0;
		if (eng_cmd == CMD_IDLE) begin
			if (op_in >= CMD_START && op_in <= CMD_READ) begin
				eng_cmd = op_in;
				eng_step = 4'd0;
				eng_bits = 4'd0;
				eng_delay = 10'd0;
				if (op_in == CMD_WRITE)
					eng_shift = byte_in;
				if (op_in == CMD_READ) begin
					eng_shift = 8'd0;
					eng_ack_sel = ack_in;
				end
				cmd_count[op_in]++;
				run_step(sda_in);
			end
		end else if (eng_delay != 10'd0) begin
			eng_delay = eng_delay - 10'd1;
		end else begin
			run_step(sda_in);
		end
		word.scl_drive = eng_scl;
		word.sda_drive = eng_sda;
		word.busy_res = (eng_cmd != CMD_IDLE);
		word.done_res = eng_done;
		word.read_data = eng_rd;
		word.ack_failed = eng_fail;
	endtask

	// prediction, checking and watchdog in one place so the order is fixed
	always @(posedge clk) begin
		res_t want;
		res_t got;
		logic moved;
		if (!arst_n) begin
			engine_reset();
			idle_cycles = 0;
		end else begin
			moved = cfg_we;
			if (cfg_we) begin
				if (cfg_index == CFG_TICKS_PER_US)
					tpu_reg = cfg_data;
				else
					ato_reg = cfg_data;
			end
			if (in_valid && !in_stall) begin
				engine_tick(op, write_data, send_ack, sda_level, want);
				pin_words_due.push_back(want);
				n_ticks++;
				moved = 1'b1;
			end
			if (out_valid && !out_stall) begin
				moved = 1'b1;
				got = {scl_drive, sda_drive, busy_res, done_res, read_data, ack_failed};
				if (pin_words_due.size() == 0) begin
					n_bad++;
					if (n_bad <= 10)
						$display("pin word with nothing due: %b", got);
				end else begin
					want = pin_words_due.pop_front();
					if (got !== want) begin
						n_bad++;
						if (n_bad <= 10) begin
							$display("word %0d want scl %b sda %b busy %b done %b rd %h fail %b",
								n_checked, want.scl_drive, want.sda_drive, want.busy_res,
								want.done_res, want.read_data, want.ack_failed);
							$display("word %0d got  scl %b sda %b busy %b done %b rd %h fail %b",
								n_checked, got.scl_drive, got.sda_drive, got.busy_res,
								got.done_res, got.read_data, got.ack_failed);
						end
					end
					n_checked++;
				end
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: nothing moved for %0d cycles", idle_cycles);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// result side: random hold-off before each word
	initial begin
		int hold;
		out_stall = 1'b0;
		forever begin
			hold = rx_steady ? 0 : $urandom_range(0, 6);
			repeat (hold) begin
				@(negedge clk);
				out_stall <= 1'b1;
			end
			@(negedge clk);
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	task automatic send_word(input logic [2:0] o, input logic [7:0] byte_out,
			input logic ack_bit, input logic sda_bit);
		int gap;
		int target;
		gap = tx_steady ? 0 : $urandom_range(0, 6);
		target = n_ticks + 1;
		@(negedge clk);
		repeat (gap) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		write_data <= byte_out;
		send_ack <= ack_bit;
		sda_level <= sda_bit;
		wait (n_ticks == target);
	endtask

	// issue one command, then tick until the engine is idle again;
	// sda goes low from tick low_at on, or is random when low_at < 0
	task automatic run_cmd(input logic [2:0] cmd, input logic [7:0] byte_out,
			input logic ack_bit, input int low_at);
		int k;
		logic sd;
		logic [2:0] o;
		k = 0;
		do begin
			if (low_at < 0)
				sd = 1'($urandom);
			else
				sd = (k >= low_at) ? 1'b0 : 1'b1;
			if (k == 0) begin
				send_word(cmd, byte_out, ack_bit, sd);
			end else begin
				// now and then a command while busy, which must be dropped
				o = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : CMD_IDLE;
				send_word(o, 8'($urandom), 1'($urandom), sd);
			end
			k++;
		end while (eng_cmd != CMD_IDLE);
	endtask

	// offset counts polls: below the timeout it acks, at or above it gives up
	task automatic await_ack(input int offset);
		int t;
		t = (tpu_reg == 8'd0) ? 1 : int'(tpu_reg);
		run_cmd(CMD_ACK, 8'($urandom), 1'($urandom), 2 * t + offset);
	endtask

	function automatic int ack_offset();
		int lim;
		lim = (ato_reg == 8'd0) ? 1 : int'(ato_reg);
		case ($urandom_range(0, 5))
			0: return lim;
			1: return lim - 1;
			2: return lim + 1 + $urandom_range(0, 3);
			default: return $urandom_range(0, (lim < 8) ? lim - 1 : 7);
		endcase
	endfunction

	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		wait (pin_words_due.size() == 0);
	endtask

	task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_timing(input logic [7:0] tpu, input logic [7:0] ato);
		settle();
		write_reg(CFG_TICKS_PER_US, tpu);
		write_reg(CFG_ACK_TIMEOUT, ato);
		n_settings++;
	endtask

	task automatic bus_transfer();
		int n;
		logic lost;
		n = $urandom_range(1, 3);
		lost = 1'b0;
		run_cmd(CMD_START, 8'($urandom), 1'($urandom), -1);
		for (int i = 0; i < n && !lost; i++) begin
			if ($urandom_range(0, 2) == 0) begin
				run_cmd(CMD_READ, 8'($urandom), 1'($urandom), -1);
			end else begin
				run_cmd(CMD_WRITE, 8'($urandom), 1'($urandom), -1);
				await_ack(ack_offset());
				lost = eng_fail;
			end
		end
		// a timeout already ends in a stop; sometimes send one more anyway
		if (!lost || $urandom_range(0, 3) == 0)
			run_cmd(CMD_STOP, 8'($urandom), 1'($urandom), -1);
	endtask

	task automatic stray_command();
		logic [2:0] pick;
		pick = 3'($urandom_range(0, 7));
		if (pick == CMD_ACK)
			await_ack(ack_offset());
		else
			run_cmd(pick, 8'($urandom), 1'($urandom), -1);
	endtask

	task automatic test_reset_timing();
		run_cmd(CMD_START, 8'h00, 1'b0, -1);
		await_ack(0);
	endtask

	task automatic test_directed_ops();
		set_timing(8'd1, 8'd3);
		run_cmd(CMD_IDLE, 8'hFF, 1'b1, -1);
		run_cmd(OP_SPARE_LO, 8'h00, 1'b0, -1);
		run_cmd(OP_SPARE_HI, 8'hFF, 1'b1, -1);
		run_cmd(CMD_START, 8'h00, 1'b0, -1);
		run_cmd(CMD_WRITE, 8'h00, 1'b0, -1);
		await_ack(0);
		run_cmd(CMD_WRITE, 8'hFF, 1'b1, -1);
		await_ack(2);
		run_cmd(CMD_WRITE, 8'h5A, 1'b0, -1);
		await_ack(3);
		run_cmd(CMD_START, 8'h00, 1'b0, -1);
		run_cmd(CMD_READ, 8'h00, 1'b1, 0);
		run_cmd(CMD_READ, 8'hFF, 1'b0, -1);
		run_cmd(CMD_READ, 8'h00, 1'b0, 1000);
		run_cmd(CMD_STOP, 8'h00, 1'b0, -1);
	endtask

	// zero in either register behaves as one
	task automatic test_zero_settings();
		set_timing(8'd0, 8'd0);
		run_cmd(CMD_START, 8'h00, 1'b0, -1);
		run_cmd(CMD_WRITE, 8'($urandom), 1'b0, -1);
		await_ack(1);
		run_cmd(CMD_START, 8'h00, 1'b0, -1);
		run_cmd(CMD_READ, 8'h00, 1'b1, -1);
		await_ack(0);
		run_cmd(CMD_STOP, 8'h00, 1'b0, -1);
	endtask

	task automatic test_slow_bus();
		set_timing(8'd255, 8'd255);
		await_ack(1);
	endtask

	task automatic test_random_traffic(input logic [7:0] tpu, input logic [7:0] ato,
			input int budget);
		int first;
		bit paused;
		set_timing(tpu, ato);
		first = n_ticks;
		paused = 1'b0;
		while (n_ticks - first < budget) begin
			tx_steady = ($urandom_range(0, 4) == 0);
			rx_steady = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 4) == 0)
				stray_command();
			else
				bus_transfer();
			// hold the sender until the result side has caught up
			if (!paused && n_ticks - first >= budget / 2) begin
				settle();
				paused = 1'b1;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_TICKS_PER_US;
		cfg_data = '0;
		in_valid = 1'b0;
		op = CMD_IDLE;
		write_data = 8'd0;
		send_ack = 1'b0;
		sda_level = 1'b1;
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_timing();
		test_directed_ops();
		test_zero_settings();
		test_slow_bus();
		test_random_traffic(8'd1, 8'd255, 40);
		test_random_traffic(8'd2, 8'd6, 40);
		test_random_traffic(8'($urandom_range(1, 3)), 8'($urandom_range(1, 20)), 40);

		settle();
		repeat (8) @(posedge clk);
		$display("%0d bus ticks under %0d timing settings, %0d pin words checked, %0d bad",
			n_ticks, n_settings, n_checked, n_bad);
		$display("commands: start %0d stop %0d write %0d read %0d ack %0d (%0d timed out)",
			cmd_count[CMD_START], cmd_count[CMD_STOP], cmd_count[CMD_WRITE],
			cmd_count[CMD_READ], cmd_count[CMD_ACK], n_timeouts);
		if (n_bad == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
